// ===== rtl/mps_pkg.sv =====
// ============================================================================
// mps_pkg
// Shared widths, register indexes, unit opcodes and the controller command
// bundle for the modular power sequence block.
// ============================================================================
package mps_pkg;

    localparam int DATA_W      = 63;
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_POWERS_DEF = 64;

    // index of the top operand bit, one step per bit
    localparam logic [IDX_W-1:0] BIT_TOP = IDX_W'(DATA_W - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

    // operations of the shared bit-serial unit
    localparam logic [1:0] OP_RDIV = 2'd0;   // secret mod (modulus - 1)
    localparam logic [1:0] OP_RMOD = 2'd1;   // element mod modulus
    localparam logic [1:0] OP_MUL  = 2'd2;   // element * secret mod modulus

    typedef struct packed {
        logic             load;       // capture base and secret
        logic             clear;      // zero the accumulator
        logic             step;       // one bit of the current operation
        logic [1:0]       op;
        logic [IDX_W-1:0] bit_idx;
        logic             wr_secret;  // step result replaces the secret
        logic             wr_cur;     // step result replaces the element
    } dp_cmd_t;

endpackage

// ===== rtl/mps_item_if.sv =====
// ============================================================================
// mps_item_if
// Input channel: one base and secret per transfer.
// ============================================================================
interface mps_item_if;
    logic                          valid;
    logic                          ready;
    logic [mps_pkg::DATA_W-1:0]    base;
    logic [mps_pkg::DATA_W-1:0]    secret;

    modport source (output valid, output base, output secret, input ready);
    modport sink   (input valid, input base, input secret, output ready);
endinterface

// ===== rtl/mps_key_if.sv =====
// ============================================================================
// mps_key_if
// Output channel: one key element per transfer.
// ============================================================================
interface mps_key_if;
    logic                          valid;
    logic                          ready;
    logic [mps_pkg::IDX_W-1:0]     power_index;
    logic [mps_pkg::DATA_W-1:0]    key_element;
    logic                          is_verifying_key;
    logic                          last;

    modport source (output valid, output power_index, output key_element,
                    output is_verifying_key, output last, input ready);
    modport sink   (input valid, input power_index, input key_element,
                    input is_verifying_key, input last, output ready);
endinterface

// ===== rtl/modular_power_sequence.sv =====
// ============================================================================
// modular_power_sequence
// Emits base * s^i mod modulus for i = 0 .. key_length-1, s = secret mod
// (modulus - 1); element 0 is the base unreduced, element 1 is flagged.
// ============================================================================
// One item at a time. A single bit-serial modular unit handles one
// operand bit per cycle for the secret reduction, the base reduction and
// each multiply. Each element waits in place until transferred. modulus
// values below 2 act as 2; key_length is clamped to 2 .. MAX_POWERS.
module modular_power_sequence #(
    parameter int MAX_POWERS = mps_pkg::MAX_POWERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mps_pkg::DATA_W-1:0]    cfg_data,
    mps_item_if.sink                      item,
    mps_key_if.source                     key
);
    import mps_pkg::*;

    logic [DATA_W-1:0] modulus_reg;
    logic [LEN_W-1:0]  key_length_reg;
    logic [DATA_W-1:0] m_eff;
    logic [LEN_W-1:0]  len_eff;
    dp_cmd_t           cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= DATA_W'(2);
            key_length_reg <= LEN_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS:    modulus_reg    <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign m_eff   = (modulus_reg < DATA_W'(2)) ? DATA_W'(2) : modulus_reg;
    assign len_eff = (key_length_reg < LEN_W'(2)) ? LEN_W'(2) :
                     (key_length_reg > LEN_W'(MAX_POWERS)) ? LEN_W'(MAX_POWERS) :
                     key_length_reg;

    mps_controller u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (item.valid),
        .in_ready         (item.ready),
        .out_valid        (key.valid),
        .out_ready        (key.ready),
        .key_length       (len_eff),
        .power_index      (key.power_index),
        .is_verifying_key (key.is_verifying_key),
        .last             (key.last),
        .cmd              (cmd)
    );

    mps_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .modulus     (m_eff),
        .base        (item.base),
        .secret      (item.secret),
        .key_element (key.key_element)
    );

    // no new item while an element is still pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> !key.valid)
        else $error("item accepted while element pending");

    // every element after the first is fully reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (key.valid && (key.power_index != '0)) |-> (key.key_element < m_eff))
        else $error("key element not reduced");

    // a multiply always separates consecutive elements
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (key.valid && key.ready && !key.last) |=> !key.valid)
        else $error("elements without a multiply between them");

    // the final element index matches the effective length
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (key.valid && key.last) |-> ({1'b0, key.power_index} == (len_eff - LEN_W'(1))))
        else $error("last flag on wrong element");

endmodule

// ===== rtl/mps_datapath.sv =====
// ============================================================================
// mps_datapath
// Operand registers and the shared bit-serial unit: restoring remainder or
// interleaved shift-add modular multiply, one operand bit per cycle.
// ============================================================================
module mps_datapath (
    input  logic                       clk,
    input  mps_pkg::dp_cmd_t           cmd,
    input  logic [mps_pkg::DATA_W-1:0] modulus,
    input  logic [mps_pkg::DATA_W-1:0] base,
    input  logic [mps_pkg::DATA_W-1:0] secret,
    output logic [mps_pkg::DATA_W-1:0] key_element
);
    import mps_pkg::*;

    logic [DATA_W-1:0] cur_reg;
    logic [DATA_W-1:0] sec_reg;
    logic [DATA_W-1:0] acc_reg;

    logic [DATA_W-1:0] divisor;
    logic              src_bit;
    logic [DATA_W:0]   rem_t;
    logic [DATA_W:0]   rem_r;
    logic [DATA_W:0]   mul_d;
    logic [DATA_W:0]   mul_d1;
    logic [DATA_W:0]   mul_d2;
    logic [DATA_W:0]   mul_d3;
    logic [DATA_W-1:0] step_res;

    assign divisor = (cmd.op == OP_RDIV) ? (modulus - DATA_W'(1)) : modulus;
    assign src_bit = (cmd.op == OP_RMOD) ? cur_reg[cmd.bit_idx] : sec_reg[cmd.bit_idx];

    always_comb
    begin
        // remainder: bring in the next dividend bit, subtract once
        rem_t = {acc_reg, src_bit};
        rem_r = (rem_t >= {1'b0, divisor}) ? (rem_t - {1'b0, divisor}) : rem_t;

        // multiply: double, reduce, conditionally add element, reduce
        mul_d  = {acc_reg, 1'b0};
        mul_d1 = (mul_d >= {1'b0, modulus}) ? (mul_d - {1'b0, modulus}) : mul_d;
        mul_d2 = src_bit ? (mul_d1 + {1'b0, cur_reg}) : mul_d1;
        mul_d3 = (mul_d2 >= {1'b0, modulus}) ? (mul_d2 - {1'b0, modulus}) : mul_d2;

        step_res = (cmd.op == OP_MUL) ? mul_d3[DATA_W-1:0] : rem_r[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.step)
        begin
            acc_reg <= step_res;
        end

        if (cmd.load)
        begin
            cur_reg <= base;
        end
        else if (cmd.wr_cur)
        begin
            cur_reg <= step_res;
        end

        if (cmd.load)
        begin
            sec_reg <= secret;
        end
        else if (cmd.wr_secret)
        begin
            sec_reg <= step_res;
        end
    end

    assign key_element = cur_reg;

endmodule

// ===== rtl/mps_controller.sv =====
// ============================================================================
// mps_controller
// Sequencer: secret reduction, then per element an emit, each but the
// last followed by one modular multiply (the first after a base reduction).
// ============================================================================
module mps_controller (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  logic [mps_pkg::LEN_W-1:0] key_length,
    output logic [mps_pkg::IDX_W-1:0] power_index,
    output logic                      is_verifying_key,
    output logic                      last,
    output mps_pkg::dp_cmd_t          cmd
);
    import mps_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_EMIT = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] bit_reg, bit_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_elem;

    assign last_elem = ({1'b0, idx_reg} == (key_length - LEN_W'(1)));

    always_comb
    begin
        state_next    = state_reg;
        bit_next      = bit_reg;
        idx_next      = idx_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.load      = 1'b0;
        cmd.clear     = 1'b0;
        cmd.step      = 1'b0;
        cmd.wr_secret = 1'b0;
        cmd.wr_cur    = 1'b0;
        cmd.bit_idx   = bit_reg;
        cmd.op        = OP_MUL;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.clear  = 1'b1;
                    bit_next   = BIT_TOP;
                    idx_next   = '0;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.op   = OP_RDIV;
                cmd.step = 1'b1;
                if (bit_reg == '0)
                begin
                    cmd.wr_secret = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    bit_next = bit_reg - IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        bit_next   = BIT_TOP;
                        idx_next   = idx_reg + IDX_W'(1);
                        // base may exceed the modulus: reduce it once first
                        state_next = (idx_reg == '0) ? ST_PREP : ST_MUL;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.op   = OP_RMOD;
                cmd.step = 1'b1;
                if (bit_reg == '0)
                begin
                    cmd.wr_cur = 1'b1;
                    cmd.clear  = 1'b1;
                    bit_next   = BIT_TOP;
                    state_next = ST_MUL;
                end
                else
                begin
                    bit_next = bit_reg - IDX_W'(1);
                end
            end
            ST_MUL:
            begin
                cmd.op   = OP_MUL;
                cmd.step = 1'b1;
                if (bit_reg == '0)
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    bit_next = bit_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            idx_reg   <= idx_next;
        end
    end

    assign power_index      = idx_reg;
    assign is_verifying_key = (idx_reg == IDX_W'(1));
    assign last             = last_elem;

endmodule
